### rtl/core/api_frame_builder_checksum_macros.svh
// Assertion macros used by the frame builder RTL.
`ifndef API_FRAME_BUILDER_CHECKSUM_MACROS_SVH
`define API_FRAME_BUILDER_CHECKSUM_MACROS_SVH

// Condition must hold in the same cycle.
`define AFB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition must hold in the next cycle.
`define AFB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/afb_pkg.sv
`timescale 1ns / 1ps

package afb_pkg;

	localparam logic [7:0] START_BYTE   = 8'h7E;
	localparam logic [7:0] LEN_HI_BYTE  = 8'h00;
	localparam logic [7:0] API_ID       = 8'h01;
	localparam logic [7:0] SEQ_ID       = 8'h01;
	localparam logic [7:0] ADDR_HI      = 8'h00;
	localparam logic [7:0] ADDR_LO      = 8'h01;
	localparam logic [7:0] OPTION_BYTE  = 8'h00;
	localparam logic [7:0] LEN_OVERHEAD = 8'd5;
	localparam logic [7:0] HEADER_SUM   = 8'd3;
	localparam logic [7:0] CHECK_BASE   = 8'hFF;
	localparam logic [7:0] MIN_PAYLOAD  = 8'd1;
	localparam logic [7:0] MAX_PAYLOAD  = 8'd250;

	localparam logic [2:0] HDR_START    = 3'd0;
	localparam logic [2:0] HDR_LEN_HI   = 3'd1;
	localparam logic [2:0] HDR_LEN_LO   = 3'd2;
	localparam logic [2:0] HDR_API      = 3'd3;
	localparam logic [2:0] HDR_FRAME    = 3'd4;
	localparam logic [2:0] HDR_ADDR_HI  = 3'd5;
	localparam logic [2:0] HDR_ADDR_LO  = 3'd6;
	localparam logic [2:0] HDR_OPTION   = 3'd7;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic [7:0] payload_length;
	} item_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_last;
	} result_t;

	typedef enum logic [1:0] {
		ST_WAIT,
		ST_HEAD,
		ST_SUM
	} state_t;

	function automatic logic [7:0] sat_len(input logic [7:0] len);
		logic [7:0] res;
		res = len;
		if (len < MIN_PAYLOAD) begin
			res = MIN_PAYLOAD;
		end else if (len > MAX_PAYLOAD) begin
			res = MAX_PAYLOAD;
		end
		return res;
	endfunction

	function automatic logic [7:0] hdr_byte(input logic [2:0] idx, input logic [7:0] len);
		logic [7:0] res;
		case (idx)
			HDR_START:   res = START_BYTE;
			HDR_LEN_HI:  res = LEN_HI_BYTE;
			HDR_LEN_LO:  res = len + LEN_OVERHEAD;
			HDR_API:     res = API_ID;
			HDR_FRAME:   res = SEQ_ID;
			HDR_ADDR_HI: res = ADDR_HI;
			HDR_ADDR_LO: res = ADDR_LO;
			HDR_OPTION:  res = OPTION_BYTE;
			default:     res = START_BYTE;
		endcase
		return res;
	endfunction

endpackage

### rtl/core/afb_in_reg.sv
`timescale 1ns / 1ps

module afb_in_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           payload_valid,
	output logic           payload_ready,
	input  afb_pkg::item_t payload,
	input  logic           take,
	output logic           item_valid,
	output afb_pkg::item_t item
);

	logic           valid_s1;
	afb_pkg::item_t item_s1;

	assign payload_ready = !valid_s1 || take;
	assign item_valid    = valid_s1;
	assign item          = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (payload_ready) begin
			valid_s1 <= payload_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (payload_valid && payload_ready) begin
			item_s1 <= payload;
		end
	end

endmodule

### rtl/core/afb_emit.sv
`timescale 1ns / 1ps
`include "api_frame_builder_checksum_macros.svh"

module afb_emit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  afb_pkg::item_t   item,
	output logic             take,
	output logic             frame_valid,
	input  logic             frame_ready,
	output afb_pkg::result_t frame
);

	afb_pkg::state_t  state_q, state_d;
	logic [7:0]       rem_q, rem_d;
	logic [7:0]       sum_q, sum_d;
	logic [2:0]       idx_q, idx_d;
	logic             out_valid_q;
	afb_pkg::result_t out_q;

	logic             emit_en;
	logic             has_byte;
	afb_pkg::result_t next_out;

	assign emit_en = !out_valid_q || frame_ready;

	// next state and frame bookkeeping
	always_comb begin
		state_d = state_q;
		rem_d   = rem_q;
		sum_d   = sum_q;
		idx_d   = idx_q;
		case (state_q)
			afb_pkg::ST_WAIT: begin
				if (item_valid) begin
					if (rem_q == 8'd0) begin
						rem_d   = afb_pkg::sat_len(item.payload_length);
						sum_d   = afb_pkg::HEADER_SUM;
						idx_d   = afb_pkg::HDR_LEN_HI;
						state_d = afb_pkg::ST_HEAD;
					end else begin
						rem_d = rem_q - 8'd1;
						sum_d = sum_q + item.payload_byte;
						if (rem_q == 8'd1) begin
							state_d = afb_pkg::ST_SUM;
						end
					end
				end
			end
			afb_pkg::ST_HEAD: begin
				idx_d = idx_q + 3'd1;
				if (idx_q == afb_pkg::HDR_OPTION) begin
					state_d = afb_pkg::ST_WAIT;
				end
			end
			afb_pkg::ST_SUM: begin
				sum_d   = 8'd0;
				state_d = afb_pkg::ST_WAIT;
			end
			default: begin
				state_d = afb_pkg::ST_WAIT;
			end
		endcase
	end

	// byte selection and item release
	always_comb begin
		has_byte            = 1'b0;
		take                = 1'b0;
		next_out.frame_byte = afb_pkg::START_BYTE;
		next_out.frame_last = 1'b0;
		case (state_q)
			afb_pkg::ST_WAIT: begin
				if (item_valid) begin
					has_byte = 1'b1;
					if (rem_q != 8'd0) begin
						next_out.frame_byte = item.payload_byte;
						take                = emit_en;
					end
				end
			end
			afb_pkg::ST_HEAD: begin
				has_byte            = 1'b1;
				next_out.frame_byte = afb_pkg::hdr_byte(idx_q, rem_q);
			end
			afb_pkg::ST_SUM: begin
				has_byte            = 1'b1;
				next_out.frame_byte = afb_pkg::CHECK_BASE - sum_q;
				next_out.frame_last = 1'b1;
			end
			default: begin
				has_byte = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= afb_pkg::ST_WAIT;
			rem_q       <= 8'd0;
			sum_q       <= 8'd0;
			idx_q       <= afb_pkg::HDR_START;
			out_valid_q <= 1'b0;
		end else if (emit_en) begin
			out_valid_q <= has_byte;
			if (has_byte) begin
				state_q <= state_d;
				rem_q   <= rem_d;
				sum_q   <= sum_d;
				idx_q   <= idx_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en && has_byte) begin
			out_q <= next_out;
		end
	end

	assign frame_valid = out_valid_q;
	assign frame       = out_q;

	`AFB_ASSERT_NOW(a_head_open, state_q == afb_pkg::ST_HEAD, rem_q != 8'd0, "header without open frame")
	`AFB_ASSERT_NOW(a_sum_closed, state_q == afb_pkg::ST_SUM, rem_q == 8'd0, "checksum with bytes left")
	`AFB_ASSERT_NOW(a_take_open, take, rem_q != 8'd0 && state_q == afb_pkg::ST_WAIT, "payload outside frame")
	`AFB_ASSERT_NEXT(a_sum_last, state_q == afb_pkg::ST_SUM && emit_en, out_valid_q && out_q.frame_last, "checksum not marked last")
	`AFB_ASSERT_NOW(a_last_idle, out_valid_q && out_q.frame_last, rem_q == 8'd0 && state_q == afb_pkg::ST_WAIT, "frame open after last byte")

endmodule

### rtl/core/api_frame_builder_checksum.sv
`timescale 1ns / 1ps
// channel   | valid         | ready         | data
// ----------+---------------+---------------+--------------------------
// payload   | payload_valid | payload_ready | payload (item_t)
// frame     | frame_valid   | frame_ready   | frame (result_t)
//
// One frame byte leaves per cycle from the output register unless frame_ready stalls
// or no payload byte waits. A mid-frame payload byte goes straight out; the first byte
// of a frame follows eight header bytes and the last byte is followed by the checksum.
// Reset clears the input stage, the sequencer and the output valid; no frame is open.
// A stall on frame_ready holds the output byte; payload_ready drops while the input
// register holds a byte that the sequencer has not taken (header, checksum or stall).

module api_frame_builder_checksum (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             payload_valid,
	output logic             payload_ready,
	input  afb_pkg::item_t   payload,
	output logic             frame_valid,
	input  logic             frame_ready,
	output afb_pkg::result_t frame
);

	logic           take;
	logic           item_valid;
	afb_pkg::item_t item;

	afb_in_reg u_in_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.payload_valid (payload_valid),
		.payload_ready (payload_ready),
		.payload       (payload),
		.take          (take),
		.item_valid    (item_valid),
		.item          (item)
	);

	afb_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item        (item),
		.take        (take),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready),
		.frame       (frame)
	);

endmodule
